[rtl/core/drc_pkg.sv]
// ----------------------------------------------------------------------------
// Distance range constraint package
// Shared types, result codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
package drc_pkg;

    localparam int Q16_W   = 32;
    localparam int REST_W  = 31;
    localparam int WIDE_W  = 64;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    typedef logic signed [Q16_W-1:0] t_q16;
    typedef logic        [Q16_W-1:0] t_uq16;
    typedef t_q16 [2:0]              t_vec3;

    typedef enum logic [1:0] {
        OUT_NONE     = 2'd0,
        OUT_STRETCH  = 2'd1,
        OUT_COMPRESS = 2'd2,
        OUT_MASS_ERR = 2'd3
    } t_outcome;

    // Register index decoded from the word address.
    localparam logic REG_REST_MIN = 1'b0;
    localparam logic REG_REST_MAX = 1'b1;

    typedef struct packed {
        t_q16  first_x;
        t_q16  first_y;
        t_q16  first_z;
        t_q16  second_x;
        t_q16  second_y;
        t_q16  second_z;
        t_uq16 first_mass;
        t_uq16 second_mass;
    } t_in;

    typedef struct packed {
        t_q16     first_dx;
        t_q16     first_dy;
        t_q16     first_dz;
        t_q16     second_dx;
        t_q16     second_dy;
        t_q16     second_dz;
        t_outcome outcome;
    } t_out;

    // Travels alongside the square root pipeline.
    typedef struct packed {
        logic  valid;
        t_vec3 n;
    } t_sqrt_side;

    // Travels alongside the mass ratio divider.
    typedef struct packed {
        logic mass_zero;
    } t_mass_side;

    // Travels alongside the correction divider.
    typedef struct packed {
        logic       valid;
        t_outcome   outcome;
        logic [2:0] nneg;
    } t_corr_side;

    function automatic t_q16 sat_diff(input t_q16 b, input t_q16 a);
        logic [Q16_W:0] d;
        d = {b[Q16_W-1], b} - {a[Q16_W-1], a};
        if (d[Q16_W] != d[Q16_W-1]) begin
            sat_diff = d[Q16_W] ? t_q16'({1'b1, {(Q16_W-1){1'b0}}})
                                : t_q16'({1'b0, {(Q16_W-1){1'b1}}});
        end else begin
            sat_diff = t_q16'(d[Q16_W-1:0]);
        end
    endfunction

    function automatic t_uq16 mag(input t_q16 v);
        mag = v[Q16_W-1] ? t_uq16'(-v) : t_uq16'(v);
    endfunction

    // Apply the sign to a truncated magnitude and saturate to 32 bits.
    function automatic t_q16 sat_corr(input t_uq16 m, input logic neg);
        if (neg) begin
            if (m > {1'b1, {(Q16_W-1){1'b0}}}) begin
                sat_corr = t_q16'({1'b1, {(Q16_W-1){1'b0}}});
            end else begin
                sat_corr = t_q16'(-m);
            end
        end else begin
            if (m[Q16_W-1]) begin
                sat_corr = t_q16'({1'b0, {(Q16_W-1){1'b1}}});
            end else begin
                sat_corr = t_q16'(m);
            end
        end
    endfunction

endpackage

[rtl/core/distance_range_constraint_unit.sv]
// ----------------------------------------------------------------------------
// Distance range constraint unit
// Position corrections that pull two particles back into a distance range.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid, i_data, o_stall) takes one pair of
// particles per item; the output channel (o_valid, o_data, i_stall) returns
// one correction item for each. The range bounds rest_min (address 0) and
// rest_max (address 4) are written through the APB port while no item is in
// flight.
// The pipeline is three input stages, a 32-stage square root running
// beside a 32-stage mass ratio divider, three scaling stages, a 32-stage
// correction divider and the output register. One bit per stage in the root
// and the dividers sets that depth.
// Throughput is one item per cycle while the receiver does not stall.
// Reset clears every valid bit and both bounds to zero.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_stall is raised in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module distance_range_constraint_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  drc_pkg::t_in               i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output drc_pkg::t_out              o_data,
    input  logic                       i_stall,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [drc_pkg::ADDR_W-1:0] paddr,
    input  logic [drc_pkg::DATA_W-1:0] pwdata,
    output logic [drc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import drc_pkg::*;

    logic w_en;

    logic [REST_W-1:0] r_rest_min, r_rest_max;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_min <= '0;
            r_rest_max <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_REST_MIN: r_rest_min <= pwdata[REST_W-1:0];
                REG_REST_MAX: r_rest_max <= pwdata[REST_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_REST_MIN: prdata = {1'b0, r_rest_min};
            REG_REST_MAX: prdata = {1'b0, r_rest_max};
            default:      prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic r_out_valid;
    t_out r_out;

    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // ---------------- stage 0: separation ----------------
    logic  r0_valid;
    t_vec3 r0_n;
    t_uq16 r0_m1, r0_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_n[0] <= sat_diff(i_data.second_x, i_data.first_x);
            r0_n[1] <= sat_diff(i_data.second_y, i_data.first_y);
            r0_n[2] <= sat_diff(i_data.second_z, i_data.first_z);
            r0_m1   <= i_data.first_mass;
            r0_m2   <= i_data.second_mass;
        end
    end

    // ---------------- stage 1: squares ----------------
    logic                    r1_valid;
    t_vec3                   r1_n;
    t_uq16                   r1_m1, r1_m2;
    logic [2:0][WIDE_W-1:0]  r1_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r1_sq[a] <= WIDE_W'(mag(r0_n[a])) * WIDE_W'(mag(r0_n[a]));
            end
            r1_n  <= r0_n;
            r1_m1 <= r0_m1;
            r1_m2 <= r0_m2;
        end
    end

    // ---------------- stage 2: sum and mass total ----------------
    logic              r2_valid;
    t_vec3             r2_n;
    t_uq16             r2_m1, r2_m2;
    logic [WIDE_W-1:0] r2_sum;
    logic [Q16_W:0]    r2_tot;
    logic              r2_mass_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sum       <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            r2_tot       <= {1'b0, r1_m1} + {1'b0, r1_m2};
            r2_mass_zero <= (r1_m1 == '0) || (r1_m2 == '0);
            r2_n         <= r1_n;
            r2_m1        <= r1_m1;
            r2_m2        <= r1_m2;
        end
    end

    // ---------------- square root and mass ratios ----------------
    t_sqrt_side               w_sq_in, w_sq_out;
    t_mass_side               w_ms_in, w_ms_out;
    logic [Q16_W-1:0]         w_d;
    logic [1:0][WIDE_W-1:0]   w_mass_num;
    logic [1:0][Q16_W-1:0]    w_ratio;

    assign w_sq_in.valid     = r2_valid;
    assign w_sq_in.n         = r2_n;
    assign w_ms_in.mass_zero = r2_mass_zero;
    // Lane 0 gives the first particle's share, lane 1 the second's.
    assign w_mass_num[0]     = {r2_m2, {Q16_W{1'b0}}};
    assign w_mass_num[1]     = {r2_m1, {Q16_W{1'b0}}};

    drc_sqrt #(
        .SW ($bits(t_sqrt_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_val   (r2_sum),
        .i_side  (w_sq_in),
        .o_root  (w_d),
        .o_side  (w_sq_out)
    );

    drc_div #(
        .LANES (2),
        .NW    (WIDE_W),
        .DW    (Q16_W + 1),
        .QW    (Q16_W),
        .SW    ($bits(t_mass_side))
    ) u_mass_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_dividend (w_mass_num),
        .i_divisor  (r2_tot),
        .i_side     (w_ms_in),
        .o_quot     (w_ratio),
        .o_side     (w_ms_out)
    );

    // ---------------- stage 3: range check ----------------
    logic             r3_valid;
    t_vec3            r3_n;
    logic [Q16_W-1:0] r3_d, r3_delta, r3_r1, r3_r2;
    t_outcome         r3_outcome;
    t_outcome         n3_outcome;
    logic [Q16_W-1:0] n3_delta;

    always_comb begin
        n3_delta = w_d - Q16_W'(r_rest_max);
        if (w_d == '0) begin
            n3_outcome = OUT_NONE;
        end else if (w_d > Q16_W'(r_rest_max)) begin
            n3_outcome = OUT_STRETCH;
        end else if (w_d < Q16_W'(r_rest_min)) begin
            n3_outcome = OUT_COMPRESS;
            n3_delta   = Q16_W'(r_rest_min) - w_d;
        end else begin
            n3_outcome = OUT_NONE;
        end
        if (n3_outcome != OUT_NONE && w_ms_out.mass_zero) begin
            n3_outcome = OUT_MASS_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= w_sq_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_n       <= w_sq_out.n;
            r3_d       <= w_d;
            r3_delta   <= n3_delta;
            r3_outcome <= n3_outcome;
            r3_r1      <= w_ratio[0];
            r3_r2      <= w_ratio[1];
        end
    end

    // ---------------- stage 4: scaled magnitudes ----------------
    logic              r4_valid;
    t_vec3             r4_n;
    logic [Q16_W-1:0]  r4_d, r4_s1, r4_s2;
    t_outcome          r4_outcome;
    logic [WIDE_W-1:0] w_p1, w_p2;

    assign w_p1 = WIDE_W'(r3_delta) * WIDE_W'(r3_r1);
    assign w_p2 = WIDE_W'(r3_delta) * WIDE_W'(r3_r2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_n       <= r3_n;
            r4_d       <= r3_d;
            r4_s1      <= w_p1[WIDE_W-1:Q16_W];
            r4_s2      <= w_p2[WIDE_W-1:Q16_W];
            r4_outcome <= r3_outcome;
        end
    end

    // ---------------- stage 5: axis products ----------------
    logic                   r5_valid;
    t_outcome               r5_outcome;
    logic [2:0]             r5_nneg;
    logic [Q16_W-1:0]       r5_d;
    logic [5:0][WIDE_W-1:0] r5_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r5_p[a]     <= WIDE_W'(mag(r4_n[a])) * WIDE_W'(r4_s1);
                r5_p[3 + a] <= WIDE_W'(mag(r4_n[a])) * WIDE_W'(r4_s2);
                r5_nneg[a]  <= r4_n[a][Q16_W-1];
            end
            r5_d       <= r4_d;
            r5_outcome <= r4_outcome;
        end
    end

    // ---------------- correction divider ----------------
    t_corr_side            w_cs_in, w_cs_out;
    logic [5:0][Q16_W-1:0] w_corr;

    assign w_cs_in.valid   = r5_valid;
    assign w_cs_in.outcome = r5_outcome;
    assign w_cs_in.nneg    = r5_nneg;

    drc_div #(
        .LANES (6),
        .NW    (WIDE_W),
        .DW    (Q16_W),
        .QW    (Q16_W),
        .SW    ($bits(t_corr_side))
    ) u_corr_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_dividend (r5_p),
        .i_divisor  (r5_d),
        .i_side     (w_cs_in),
        .o_quot     (w_corr),
        .o_side     (w_cs_out)
    );

    // ---------------- output register ----------------
    t_out n_out;

    always_comb begin
        logic comp;
        logic active;
        comp   = (w_cs_out.outcome == OUT_COMPRESS);
        active = (w_cs_out.outcome == OUT_STRETCH) || comp;
        n_out  = '0;
        n_out.outcome = w_cs_out.outcome;
        if (active) begin
            // The first particle moves along the axis when stretched, the
            // second one the other way.
            n_out.first_dx  = sat_corr(w_corr[0], w_cs_out.nneg[0] ^ comp);
            n_out.first_dy  = sat_corr(w_corr[1], w_cs_out.nneg[1] ^ comp);
            n_out.first_dz  = sat_corr(w_corr[2], w_cs_out.nneg[2] ^ comp);
            n_out.second_dx = sat_corr(w_corr[3], w_cs_out.nneg[0] ^ !comp);
            n_out.second_dy = sat_corr(w_corr[4], w_cs_out.nneg[1] ^ !comp);
            n_out.second_dz = sat_corr(w_corr[5], w_cs_out.nneg[2] ^ !comp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_cs_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/core/drc_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per register stage over a 64-bit radicand, 32 stages.
// ----------------------------------------------------------------------------
module drc_sqrt #(
    parameter int SW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [drc_pkg::WIDE_W-1:0] i_val,
    input  logic [SW-1:0]              i_side,
    output logic [drc_pkg::Q16_W-1:0]  o_root,
    output logic [SW-1:0]              o_side
);
    import drc_pkg::*;

    localparam int STAGES = WIDE_W / 2;

    logic [WIDE_W-1:0] w_v    [STAGES+1];
    logic [WIDE_W-1:0] w_res  [STAGES+1];
    logic [SW-1:0]     w_side [STAGES+1];

    assign w_v[0]    = i_val;
    assign w_res[0]  = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [WIDE_W-1:0] BIT = WIDE_W'(1) << (WIDE_W - 2 - 2*k);

        logic [WIDE_W-1:0] n_v, n_res, r_v, r_res;
        logic [SW-1:0]     r_side;

        always_comb begin
            logic [WIDE_W-1:0] t;
            t = w_res[k] + BIT;
            if (w_v[k] >= t) begin
                n_v   = w_v[k] - t;
                n_res = (w_res[k] >> 1) + BIT;
            end else begin
                n_v   = w_v[k];
                n_res = w_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else if (i_en) begin
                r_side <= w_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v   <= n_v;
                r_res <= n_res;
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_res[k+1]  = r_res;
        assign w_side[k+1] = r_side;
    end

    assign o_root = w_res[STAGES][Q16_W-1:0];
    assign o_side = w_side[STAGES];

endmodule

[rtl/core/drc_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides several dividends by one shared divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module drc_div #(
    parameter int LANES = 1,
    parameter int NW    = 64,
    parameter int DW    = 32,
    parameter int QW    = 32,
    parameter int SW    = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [LANES-1:0][NW-1:0]       i_dividend,
    input  logic [DW-1:0]                  i_divisor,
    input  logic [SW-1:0]                  i_side,
    output logic [LANES-1:0][QW-1:0]       o_quot,
    output logic [SW-1:0]                  o_side
);
    import drc_pkg::*;

    // The caller guarantees that the upper dividend bits stay below the divisor,
    // so the quotient fits in QW bits.
    logic [LANES-1:0][DW-1:0] w_rem  [QW+1];
    logic [LANES-1:0][QW-1:0] w_q    [QW+1];
    logic [DW-1:0]            w_div  [QW+1];
    logic [SW-1:0]            w_side [QW+1];

    for (genvar l = 0; l < LANES; l++) begin : g_init
        assign w_rem[0][l] = DW'(i_dividend[l][NW-1:QW]);
        assign w_q[0][l]   = i_dividend[l][QW-1:0];
    end
    assign w_div[0]  = i_divisor;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [LANES-1:0][DW-1:0] n_rem, r_rem;
        logic [LANES-1:0][QW-1:0] n_q, r_q;
        logic [DW-1:0]            r_div;
        logic [SW-1:0]            r_side;

        // Dividend bits leave the top of the quotient word as quotient bits
        // enter at the bottom.
        always_comb begin
            logic [DW:0] sh;
            logic [DW:0] diff;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
                sh   = {w_rem[k][l], w_q[k][l][QW-1]};
                diff = sh - {1'b0, w_div[k]};
                ge   = (sh >= {1'b0, w_div[k]});
                n_rem[l] = ge ? diff[DW-1:0] : sh[DW-1:0];
                n_q[l]   = {w_q[k][l][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else if (i_en) begin
                r_side <= w_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_div <= w_div[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_q[k+1]    = r_q;
        assign w_div[k+1]  = r_div;
        assign w_side[k+1] = r_side;
    end

    assign o_quot = w_q[QW];
    assign o_side = w_side[QW];

endmodule
